// File: hdl/bfm_pkg.sv
`default_nettype none

package bfm_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    FUNC_NEW_PATTERN = 2'd0,
    FUNC_APPEND      = 2'd1,
    FUNC_RESTART     = 2'd2,
    FUNC_TEXT        = 2'd3
  } func_t;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SCORE_W  = 24;
  localparam int unsigned SUM_W    = SCORE_W + 2;
  localparam int unsigned HITS_W   = 3;
  localparam int unsigned MAXD_W   = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX  = 24'hFF_FFFF;
  localparam logic [MAXD_W-1:0]  MAXD_RESET = 2'd2;
  localparam logic [MAXD_W-1:0]  MAXD_LIMIT = 2'd2;

  // case folding of upper-case letters
  localparam int UPPER_A     = 65;
  localparam int UPPER_Z     = 90;
  localparam int CASE_OFFSET = 32;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_DIST_LIMIT = 1'b0;

endpackage

`default_nettype wire

// File: hdl/bfm_front.sv
`default_nettype none

module bfm_front #(
  parameter int ALPHABET_SIZE = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_func,
  input  wire logic [bfm_pkg::CHAR_W-1:0]      in_character,
  output logic                                 q_valid,
  input  wire logic                            q_pop,
  output bfm_pkg::func_t                       q_func,
  output logic [$clog2(ALPHABET_SIZE)-1:0]     q_idx
);

  localparam int IDX_W = $clog2(ALPHABET_SIZE);

  // folded character to mask index, built at elaboration
  typedef logic [IDX_W-1:0] fold_tab_t [256];

  function automatic fold_tab_t build_fold_tab();
    fold_tab_t tab;
    int        v;
    for (int c = 0; c < 256; c++) begin
      v = c;
      if (v >= bfm_pkg::UPPER_A && v <= bfm_pkg::UPPER_Z) begin
        v = v + bfm_pkg::CASE_OFFSET;
      end
      tab[c] = IDX_W'(v % ALPHABET_SIZE);
    end
    return tab;
  endfunction

  localparam fold_tab_t FOLD_TAB = build_fold_tab();

  // two-entry queue towards the back end
  bfm_pkg::func_t   fifo_func_r [2];
  logic [IDX_W-1:0] fifo_idx_r  [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_func   = fifo_func_r[rd_ptr_r];
  assign q_idx    = fifo_idx_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_func_r[wr_ptr_r] <= bfm_pkg::func_t'(in_func);
      fifo_idx_r[wr_ptr_r]  <= FOLD_TAB[in_character];
    end
  end

endmodule

`default_nettype wire

// File: hdl/bfm_back.sv
`default_nettype none

module bfm_back #(
  parameter int ALPHABET_SIZE = 128,
  parameter int MAX_PATTERN   = 63
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  output logic                                 q_pop,
  input  wire bfm_pkg::func_t                  q_func,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0] q_idx,
  input  wire logic [bfm_pkg::MAXD_W-1:0]      dist_limit,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bfm_pkg::SCORE_W-1:0]          out_score,
  output logic [bfm_pkg::HITS_W-1:0]           out_hit_flags,
  output logic                                 out_pattern_overflow
);

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam int W     = MAX_PATTERN + 1;
  localparam int LEN_W = $clog2(W);

  localparam logic [W-1:0]     ROW0_INIT = ~W'(1);
  localparam logic [W-1:0]     ROW1_INIT = ~W'(1) << 1;
  localparam logic [W-1:0]     ROW2_INIT = ~W'(1) << 2;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_PATTERN);

  // mask memory, entries without a valid bit read as all ones
  logic [W-1:0]             mask_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] vld_r;

  // read stage
  logic                     rd_v_r;
  bfm_pkg::func_t           rd_func_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic [W-1:0]             mem_rd_r;
  logic                     vld_rd_r;
  logic                     fwd_clr_r;
  logic                     fwd_wr_r;
  logic [W-1:0]             fwd_data_r;

  // matcher state
  logic [W-1:0]                 row0_r, row1_r, row2_r;
  logic [W-1:0]                 row0_nxt, row1_nxt, row2_nxt;
  logic [LEN_W-1:0]             len_r, len_nxt;
  logic [bfm_pkg::SCORE_W-1:0]  score_r, score_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [bfm_pkg::HITS_W-1:0]   hits_nxt;

  // output register
  logic                         out_v_r;
  logic [bfm_pkg::SCORE_W-1:0]  out_score_r;
  logic [bfm_pkg::HITS_W-1:0]   out_hits_r;
  logic                         out_ovf_r;

  logic                         exec_fire;
  logic                         rd_load;
  logic                         wr_en;
  logic [W-1:0]                 wr_data;
  logic [W-1:0]                 cur_mask;
  logic [W-1:0]                 r0c, r1c, r2c;
  logic [bfm_pkg::MAXD_W-1:0]   maxd_sat, md;
  logic [7:0]                   len_ext, g1, g2;
  logic [bfm_pkg::HITS_W-1:0]   hits_txt;
  logic [bfm_pkg::SUM_W-1:0]    score_sum;
  logic [bfm_pkg::SCORE_W-1:0]  score_txt;

  assign exec_fire = rd_v_r && (!out_v_r || out_ready);
  assign rd_load   = q_valid && (!rd_v_r || exec_fire);
  assign q_pop     = rd_load;

  always_comb begin
    if (fwd_clr_r) begin
      cur_mask = '1;
    end else if (fwd_wr_r) begin
      cur_mask = fwd_data_r;
    end else if (vld_rd_r) begin
      cur_mask = mem_rd_r;
    end else begin
      cur_mask = '1;
    end
  end

  assign wr_en   = exec_fire && (rd_func_r == bfm_pkg::FUNC_APPEND) && (len_r < LEN_LIMIT);
  assign wr_data = cur_mask & ~(W'(1) << len_r);

  // row updates, each row leans on the one below
  always_comb begin
    r0c = (row0_r | cur_mask) << 1;
    r1c = ((row1_r | cur_mask) << 1) & row0_r & (r0c << 1) & (row0_r << 1);
    r2c = ((row2_r | cur_mask) << 1) & row1_r & (r1c << 1) & (row1_r << 1);

    maxd_sat = (dist_limit > bfm_pkg::MAXD_LIMIT) ? bfm_pkg::MAXD_LIMIT : dist_limit;
    if ((LEN_W + 2)'(len_r) < (LEN_W + 2)'(maxd_sat)) begin
      md = 2'(len_r);
    end else begin
      md = maxd_sat;
    end

    hits_txt[0] = !r0c[len_r];
    hits_txt[1] = (md >= 2'd1) && !r1c[len_r];
    hits_txt[2] = (md >= 2'd2) && !r2c[len_r];

    len_ext = 8'(len_r);
    g1 = (len_ext >= 8'd2) ? len_ext - 8'd2 : 8'd0;
    g2 = (len_ext >= 8'd4) ? len_ext - 8'd4 : 8'd0;

    score_sum = bfm_pkg::SUM_W'(score_r)
              + (hits_txt[0] ? bfm_pkg::SUM_W'(len_ext) : '0)
              + (hits_txt[1] ? bfm_pkg::SUM_W'(g1) : '0)
              + (hits_txt[2] ? bfm_pkg::SUM_W'(g2) : '0);
    if (score_sum > bfm_pkg::SUM_W'(bfm_pkg::SCORE_MAX)) begin
      score_txt = bfm_pkg::SCORE_MAX;
    end else begin
      score_txt = score_sum[bfm_pkg::SCORE_W-1:0];
    end

    row0_nxt  = row0_r;
    row1_nxt  = row1_r;
    row2_nxt  = row2_r;
    len_nxt   = len_r;
    score_nxt = score_r;
    ovf_nxt   = ovf_r;
    hits_nxt  = '0;
    case (rd_func_r)
      bfm_pkg::FUNC_NEW_PATTERN: begin
        row0_nxt  = ROW0_INIT;
        row1_nxt  = ROW1_INIT;
        row2_nxt  = ROW2_INIT;
        len_nxt   = '0;
        score_nxt = '0;
        ovf_nxt   = 1'b0;
      end
      bfm_pkg::FUNC_APPEND: begin
        if (len_r < LEN_LIMIT) begin
          len_nxt = len_r + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      bfm_pkg::FUNC_RESTART: begin
        row0_nxt  = ROW0_INIT;
        row1_nxt  = ROW1_INIT;
        row2_nxt  = ROW2_INIT;
        score_nxt = '0;
      end
      bfm_pkg::FUNC_TEXT: begin
        row0_nxt = r0c;
        if (md >= 2'd1) begin
          row1_nxt = r1c;
        end
        if (md >= 2'd2) begin
          row2_nxt = r2c;
        end
        score_nxt = score_txt;
        hits_nxt  = hits_txt;
      end
      default: begin
        hits_nxt = '0;
      end
    endcase
  end

  // mask memory port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[rd_idx_r] <= wr_data;
    end
    if (rd_load) begin
      mem_rd_r <= mask_mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (exec_fire && (rd_func_r == bfm_pkg::FUNC_NEW_PATTERN)) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[rd_idx_r] <= 1'b1;
    end
  end

  // read stage, with forwarding of the write that lands on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (rd_load) begin
      rd_v_r <= 1'b1;
    end else if (exec_fire) begin
      rd_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_load) begin
      rd_func_r  <= q_func;
      rd_idx_r   <= q_idx;
      vld_rd_r   <= vld_r[q_idx];
      fwd_clr_r  <= exec_fire && (rd_func_r == bfm_pkg::FUNC_NEW_PATTERN);
      fwd_wr_r   <= wr_en && (rd_idx_r == q_idx);
      fwd_data_r <= wr_data;
    end
  end

  // matcher state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r  <= ROW0_INIT;
      row1_r  <= ROW1_INIT;
      row2_r  <= ROW2_INIT;
      len_r   <= '0;
      score_r <= '0;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (exec_fire) begin
        row0_r  <= row0_nxt;
        row1_r  <= row1_nxt;
        row2_r  <= row2_nxt;
        len_r   <= len_nxt;
        score_r <= score_nxt;
        ovf_r   <= ovf_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_score_r <= score_nxt;
      out_hits_r  <= hits_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_valid            = out_v_r;
  assign out_score            = out_score_r;
  assign out_hit_flags        = out_hits_r;
  assign out_pattern_overflow = out_ovf_r;

endmodule

`default_nettype wire

// File: hdl/bitap_fuzzy_match_scorer_core.sv
`default_nettype none

// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// in        | in_valid / in_ready       | in_func[1:0], in_character[7:0]
// out       | out_valid / out_ready     | out_score[23:0], out_hit_flags[2:0],
//           |                           | out_pattern_overflow
// cfg (apb) | psel, penable, pwrite,    | paddr[2:0], pwdata[31:0], prdata[31:0]
//           | pready (tied high)        |
//
// one item per cycle sustained while out_ready is high; each taken item goes through
// queue write, then mask memory read, then row and score update into the result register
// the pace is set by the row and score update in the back end
// synchronous active-low reset; the mask valid bits clear all at once, no sweep
// a new pattern clears the valid bits at once, so the next item runs straight on
// a stalled output holds the back end; the two-entry queue takes items until it fills

module bitap_fuzzy_match_scorer_core #(
  parameter int ALPHABET_SIZE = 128,
  parameter int MAX_PATTERN   = 63
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // item input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_func,
  input  wire logic [bfm_pkg::CHAR_W-1:0]      in_character,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bfm_pkg::SCORE_W-1:0]          out_score,
  output logic [bfm_pkg::HITS_W-1:0]           out_hit_flags,
  output logic                                 out_pattern_overflow,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bfm_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [bfm_pkg::PDATA_W-1:0]     pwdata,
  output logic [bfm_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  localparam int IDX_W = $clog2(ALPHABET_SIZE);

  // distance register
  logic [bfm_pkg::MAXD_W-1:0]   dist_limit_r;
  logic [bfm_pkg::PADDR_W-3:0]  reg_idx;
  logic                         reg_wr;

  // front to back queue
  logic                         q_valid;
  logic                         q_pop;
  bfm_pkg::func_t               q_func;
  logic [IDX_W-1:0]             q_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bfm_pkg::PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_limit_r <= bfm_pkg::MAXD_RESET;
    end else if (reg_wr && (reg_idx == bfm_pkg::REG_DIST_LIMIT)) begin
      dist_limit_r <= pwdata[bfm_pkg::MAXD_W-1:0];
    end
  end

  // reads of addresses past the one register give zero
  always_comb begin
    if (reg_idx == bfm_pkg::REG_DIST_LIMIT) begin
      prdata = {{(bfm_pkg::PDATA_W - bfm_pkg::MAXD_W){1'b0}}, dist_limit_r};
    end else begin
      prdata = '0;
    end
  end

  // front end: takes items, folds case and maps to a mask index
  bfm_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_character (in_character),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_func       (q_func),
    .q_idx        (q_idx)
  );

  // back end: mask memory, row words, score and the result register
  bfm_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_PATTERN   (MAX_PATTERN)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_pop                (q_pop),
    .q_func               (q_func),
    .q_idx                (q_idx),
    .dist_limit           (dist_limit_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_score            (out_score),
    .out_hit_flags        (out_hit_flags),
    .out_pattern_overflow (out_pattern_overflow)
  );

endmodule

`default_nettype wire

// File: bench/tb_bitap_fuzzy_match_scorer_core.sv
`timescale 1ns / 100ps

module tb_bitap_fuzzy_match_scorer_core;

  localparam int ALPHA   = 128;
  localparam int MAX_PAT = 63;
  // generous ceiling: several times the slowest run the stimulus can make
  localparam int LIMIT_NS = 2_000_000;
  localparam logic [bfm_pkg::PADDR_W-1:0] DIST_ADDR = {bfm_pkg::REG_DIST_LIMIT, 2'b00};

  // one result item as the block reports it
  typedef struct packed {
    logic [bfm_pkg::SCORE_W-1:0] score;
    logic [bfm_pkg::HITS_W-1:0]  hits;
    logic                        ovf;
  } match_result_t;

  // one row of the directed table; typed rows carry the result read off by eye
  typedef struct packed {
    bfm_pkg::func_t op;
    logic [7:0]     ch;
    logic           typed;
    match_result_t  want;
  } stim_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  // block inputs, all known from time zero
  logic                         in_valid = 1'b0;
  bfm_pkg::func_t               in_func = bfm_pkg::FUNC_TEXT;
  logic [bfm_pkg::CHAR_W-1:0]   in_character = '0;
  logic                         out_ready = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [bfm_pkg::PADDR_W-1:0]  paddr = '0;
  logic [bfm_pkg::PDATA_W-1:0]  pwdata = '0;

  // block outputs
  logic                         in_ready;
  logic                         out_valid;
  logic [bfm_pkg::SCORE_W-1:0]  out_score;
  logic [bfm_pkg::HITS_W-1:0]   out_hit_flags;
  logic                         out_pattern_overflow;
  logic [bfm_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  bitap_fuzzy_match_scorer_core #(
    .ALPHABET_SIZE(ALPHA),
    .MAX_PATTERN  (MAX_PAT)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_character        (in_character),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_score           (out_score),
    .out_hit_flags       (out_hit_flags),
    .out_pattern_overflow(out_pattern_overflow),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // ---------------------------------------------------------------------------
  // matcher model: case-folded mask table, three row words, running score
  // ---------------------------------------------------------------------------
  logic [63:0]                 char_mask [ALPHA];
  logic [63:0]                 row_word [3];
  int unsigned                 pat_len;
  logic [bfm_pkg::SCORE_W-1:0] run_score;
  logic                        ovf_seen;
  logic [bfm_pkg::MAXD_W-1:0]  dist_reg;

  match_result_t awaited_results [$];   // scores still owed by the block
  stim_row_t     directed_rows [$];
  int unsigned   items_sent = 0;
  int unsigned   mismatches = 0;
  bit            bursts_on = 1'b1;      // random idling on both sides
  int unsigned   stall_left = 0;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // upper-case letters fold to lower, then the byte wraps onto the alphabet
  function automatic int unsigned fold_char(input logic [7:0] c);
    int unsigned v;
    v = 32'(c);
    if (v >= bfm_pkg::UPPER_A && v <= bfm_pkg::UPPER_Z) v += bfm_pkg::CASE_OFFSET;
    return v % ALPHA;
  endfunction

  task automatic restart_rows();
    row_word[0] = ~64'd1;
    row_word[1] = ~64'd1 << 1;
    row_word[2] = ~64'd1 << 2;
  endtask

  // state of a freshly cleared pattern, also the state after reset
  task automatic fresh_pattern();
    foreach (char_mask[i]) char_mask[i] = '1;
    pat_len   = 0;
    ovf_seen  = 1'b0;
    run_score = '0;
    restart_rows();
  endtask

  task automatic advance_matcher(input bfm_pkg::func_t op, input logic [7:0] ch,
                                 output match_result_t res);
    logic [63:0]                mask;
    logic [63:0]                parent;
    logic [63:0]                prev;
    logic [bfm_pkg::HITS_W-1:0] hits;
    int unsigned                md;
    int unsigned                pen;
    int unsigned                total;
    hits = '0;
    mask = char_mask[fold_char(ch)];
    case (op)
      bfm_pkg::FUNC_NEW_PATTERN: fresh_pattern();
      bfm_pkg::FUNC_APPEND: begin
        if (pat_len < MAX_PAT) begin
          char_mask[fold_char(ch)][pat_len] = 1'b0;
          pat_len++;
        end else begin
          ovf_seen = 1'b1;   // byte dropped, flag sticks until the next pattern
        end
      end
      bfm_pkg::FUNC_RESTART: begin
        restart_rows();
        run_score = '0;
      end
      default: begin
        // register value three behaves as two; never more rows than pattern bytes
        md = (dist_reg > bfm_pkg::MAXD_LIMIT) ? 32'(bfm_pkg::MAXD_LIMIT) : 32'(dist_reg);
        if (md > pat_len) md = pat_len;
        parent = row_word[0];
        row_word[0] = (row_word[0] | mask) << 1;
        for (int unsigned j = 1; j <= md; j++) begin
          prev = row_word[j];
          row_word[j] = ((prev | mask) << 1) & parent & (row_word[j-1] << 1) & (parent << 1);
          parent = prev;
        end
        // a clear bit at the pattern length means a match ends on this byte
        for (int unsigned j = 0; j <= md; j++) begin
          if (row_word[j][pat_len] == 1'b0) begin
            pen = 2 * j;
            if (pen > pat_len) pen = pat_len;
            hits[j] = 1'b1;
            total = 32'(run_score) + (pat_len - pen);
            run_score = (total > 32'(bfm_pkg::SCORE_MAX)) ? bfm_pkg::SCORE_MAX
                                                          : total[bfm_pkg::SCORE_W-1:0];
          end
        end
      end
    endcase
    res.score = run_score;
    res.hits  = hits;
    res.ovf   = ovf_seen;
  endtask

  // ---------------------------------------------------------------------------
  // item sender: valid held with a steady payload until taken
  // ---------------------------------------------------------------------------
  task automatic send_item(input bfm_pkg::func_t op, input logic [7:0] ch,
                           input bit use_fixed = 1'b0,
                           input match_result_t fixed = '0);
    match_result_t res;
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= op;
    in_character <= ch;
    do @(posedge clk); while (!in_ready);
    advance_matcher(op, ch, res);
    awaited_results.push_back(use_fixed ? fixed : res);
    items_sent++;
  endtask

  // sender stands back until every owed result has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write then read-back over the apb port, block idle
  task automatic write_dist_limit(input logic [bfm_pkg::MAXD_W-1:0] value);
    logic [bfm_pkg::PDATA_W-1:0] readback;
    hold_until_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIST_ADDR;
    pwdata  <= bfm_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dist_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== bfm_pkg::PDATA_W'(value))
      flag_mismatch($sformatf("distance limit reads %0h, wrote %0h", readback, value));
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] swap_case(input logic [7:0] c);
    if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  // mostly a small alphabet so that patterns actually match
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'("a" + $urandom_range(0, 3)) | 8'h80;  // wraps onto a lower-case mask
      default: return swap_case(8'("a" + $urandom_range(0, 3)));
    endcase
  endfunction

  // well-formed sessions: a pattern, then text built from it with a few edits,
  // sprinkled with noise, restarts and late pattern bytes
  task automatic run_random(input int unsigned target);
    logic [7:0]  pat [$];
    logic [7:0]  c;
    int unsigned len;
    while (items_sent < target) begin
      bursts_on = ($urandom_range(0, 3) != 0);
      send_item(bfm_pkg::FUNC_NEW_PATTERN, 8'($urandom_range(0, 255)));
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
      pat.delete();
      repeat (len) begin
        c = pick_char();
        pat.push_back(c);
        send_item(bfm_pkg::FUNC_APPEND, c);
      end
      repeat ($urandom_range(3, 10)) begin
        case ($urandom_range(0, 9))
          0: send_item(bfm_pkg::FUNC_RESTART, 8'($urandom_range(0, 255)));
          1: begin
            // pattern grows mid-search, rows carry on
            c = pick_char();
            pat.push_back(c);
            send_item(bfm_pkg::FUNC_APPEND, c);
          end
          2, 3: repeat ($urandom_range(1, 4)) send_item(bfm_pkg::FUNC_TEXT, pick_char());
          default: begin
            foreach (pat[i]) begin
              case ($urandom_range(0, 15))
                0: ;  // deletion: pattern byte left out of the text
                1: send_item(bfm_pkg::FUNC_TEXT, pick_char());  // replacement
                2: begin
                  send_item(bfm_pkg::FUNC_TEXT, pick_char());   // insertion
                  send_item(bfm_pkg::FUNC_TEXT, swap_case(pat[i]));
                end
                default: send_item(bfm_pkg::FUNC_TEXT, swap_case(pat[i]));
              endcase
            end
          end
        endcase
      end
    end
  endtask

  task automatic add_row(input bfm_pkg::func_t op, input logic [7:0] ch,
                         input logic typed = 1'b0, input match_result_t want = '0);
    stim_row_t row;
    row.op    = op;
    row.ch    = ch;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // result receiver with random stall bursts; compares against the oldest owed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    match_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result score %0d hits %b ovf %b",
                                out_score, out_hit_flags, out_pattern_overflow));
      end else begin
        want = awaited_results.pop_front();
        if (out_score !== want.score)
          flag_mismatch($sformatf("score %0d, expected %0d", out_score, want.score));
        if (out_hit_flags !== want.hits)
          flag_mismatch($sformatf("hit_flags %b, expected %b", out_hit_flags, want.hits));
        if (out_pattern_overflow !== want.ovf)
          flag_mismatch($sformatf("pattern_overflow %b, expected %b",
                                  out_pattern_overflow, want.ovf));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run ceiling
  initial begin
    #LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    fresh_pattern();
    dist_reg = bfm_pkg::MAXD_RESET;

    // directed table; the register is still at its reset value of two
    add_row(bfm_pkg::FUNC_TEXT, "x", 1'b1, {24'd0, 3'b001, 1'b0});  // empty pattern after reset
    add_row(bfm_pkg::FUNC_TEXT, 8'hFF, 1'b1, {24'd0, 3'b001, 1'b0});
    add_row(bfm_pkg::FUNC_NEW_PATTERN, 8'hFF, 1'b1, {24'd0, 3'b000, 1'b0});
    add_row(bfm_pkg::FUNC_APPEND, "A", 1'b1, {24'd0, 3'b000, 1'b0});  // folds to lower case
    add_row(bfm_pkg::FUNC_APPEND, "b", 1'b1, {24'd0, 3'b000, 1'b0});
    add_row(bfm_pkg::FUNC_APPEND, "C", 1'b1, {24'd0, 3'b000, 1'b0});
    add_row(bfm_pkg::FUNC_TEXT, "a");
    add_row(bfm_pkg::FUNC_TEXT, "B");
    add_row(bfm_pkg::FUNC_TEXT, "c");                                  // exact match
    add_row(bfm_pkg::FUNC_TEXT, "a");
    add_row(bfm_pkg::FUNC_TEXT, "x");                                  // one replacement
    add_row(bfm_pkg::FUNC_TEXT, "c");
    add_row(bfm_pkg::FUNC_TEXT, 8'hE1);                                // wraps onto 'a'
    add_row(bfm_pkg::FUNC_TEXT, 8'h00);
    add_row(bfm_pkg::FUNC_APPEND, "d");                                // pattern grows mid-search
    add_row(bfm_pkg::FUNC_TEXT, "d");
    add_row(bfm_pkg::FUNC_RESTART, 8'h00, 1'b1, {24'd0, 3'b000, 1'b0});
    add_row(bfm_pkg::FUNC_TEXT, "b");
    add_row(bfm_pkg::FUNC_TEXT, "c");
    add_row(bfm_pkg::FUNC_TEXT, "D");
    add_row(bfm_pkg::FUNC_NEW_PATTERN, 8'h00, 1'b1, {24'd0, 3'b000, 1'b0});
    add_row(bfm_pkg::FUNC_TEXT, 8'h7F, 1'b1, {24'd0, 3'b001, 1'b0});  // empty pattern again

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].typed,
                directed_rows[i].want);

    // random sessions across the register settings, extremes included
    write_dist_limit(2'd0);
    run_random(450);
    write_dist_limit(2'd1);
    run_random(900);
    write_dist_limit(2'd3);
    run_random(1100);
    hold_until_drained();
    run_random(1350);
    write_dist_limit(2'd2);
    run_random(1650);

    // last stretch, no idling: overlong pattern, then a long run of matches on it
    hold_until_drained();
    bursts_on = 1'b0;
    send_item(bfm_pkg::FUNC_NEW_PATTERN, 8'h00);
    repeat (MAX_PAT) send_item(bfm_pkg::FUNC_APPEND, swap_case("a"));
    send_item(bfm_pkg::FUNC_APPEND, 8'h00, 1'b1, {24'd0, 3'b000, 1'b1});
    send_item(bfm_pkg::FUNC_APPEND, 8'hFF, 1'b1, {24'd0, 3'b000, 1'b1});
    repeat (80) send_item(bfm_pkg::FUNC_TEXT, swap_case("a"));
    send_item(bfm_pkg::FUNC_RESTART, 8'h55);
    repeat (4) send_item(bfm_pkg::FUNC_TEXT, "a");

    // drain, then allow for the pipeline depth
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
